// ===== src/lpc_pkg.sv =====
// Shared types, constants and the step table for the loop playhead controller.
// Used by lpc_step_pipe, lpc_core and loop_playhead_controller_unit.
package lpc_pkg;

  // Fixed point layout of the playhead
  localparam int FRAME_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int POS_W      = FRAME_BITS + FRAC_BITS + 1;
  // Working width for the tick update, leaves room for several loop adjustments
  localparam int WIDE_W     = FRAME_BITS + FRAC_BITS + 7;
  // Comparison width for 16-bit inputs against frame numbers
  localparam int LEN_CMP_W  = (FRAME_BITS > 16) ? FRAME_BITS : 16;

  localparam logic [FRAME_BITS-1:0] FRAME_MAX = '1;
  localparam longint POS_HI_L = (longint'(1) << (FRAME_BITS + FRAC_BITS)) - 1;
  localparam longint POS_LO_L = -(longint'(1) << (FRAME_BITS + FRAC_BITS));

  // Step arithmetic: rate_scale * speed, then floor division by TICK_DIV
  localparam int TICK_DIV   = 25;
  localparam int PROD_W     = 24;
  localparam int QUOT_W     = 20;
  localparam int REM_W      = 5;
  localparam int RECIP_SH   = 29;
  localparam longint RECIP_K = ((longint'(1) << RECIP_SH) + TICK_DIV - 1) / TICK_DIV;
  localparam int RECIP_W    = 25;
  localparam int STEP_SH    = FRAC_BITS - 8;
  localparam int STEP_W     = FRAC_BITS + 12;
  localparam int TAB_W      = FRAC_BITS - 7;

  // Loop policy
  localparam logic [2:0] CNT_MAX    = 3'd7;
  localparam logic [2:0] LOOP_LIMIT = 3'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_ENABLE      = 2'd0;
  localparam logic [1:0] CFG_CLIP_LENGTH = 2'd1;
  localparam logic [1:0] CFG_RATE_SCALE  = 2'd2;

  // Request kinds
  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_SPEED   = 2'd1,
    REQ_TRIGGER = 2'd2,
    REQ_JUMP    = 2'd3
  } req_t;

  // Held trigger level
  typedef enum logic [1:0] {
    TRIG_ZERO = 2'd0,
    TRIG_POS  = 2'd1,
    TRIG_NEG  = 2'd2
  } trig_t;

  // Request with its precomputed step, handed to the core
  typedef struct packed {
    logic                      valid;
    req_t                      req;
    logic signed [15:0]        speed_value;
    logic signed [16:0]        int_value;
    logic signed [STEP_W-1:0]  step;
  } item_t;

  // Fraction part of the step for each remainder: floor(rem * 2^STEP_SH / 25)
  typedef logic [TAB_W-1:0] step_tab_t [TICK_DIV];

  function automatic step_tab_t make_step_tab();
    step_tab_t t;
    longint    v;
    for (int i = 0; i < TICK_DIV; i++) begin
      v    = longint'(i) << STEP_SH;
      t[i] = TAB_W'((v * RECIP_K) >> RECIP_SH);
    end
    return t;
  endfunction

endpackage

// ===== src/loop_playhead_controller_unit.sv =====
// Top level of the loop playhead controller: configuration registers and the
// stream ports. Instantiates lpc_step_pipe and lpc_core; uses lpc_pkg.
//
//  channel   direction  handshake             payload
//  s_*       in         s_tvalid / s_tready   tuser: req_type; tdata: speed, int value
//  m_*       out        m_tvalid / m_tready   tdata: frame_position, looping
//  cfg_*     in         cfg_en                cfg_index, cfg_data
//
// One request per cycle is accepted while no held tick backs up the step pipe; a
// tick result passes the step stages (product, quotient, step), then the state
// update and result register, which raise m_tvalid.
// The state update and result register set the one-cycle rate; the step pipe
// keeps accepting while a result waits, until a tick reaches the core.
// Reset (rst, synchronous) clears the state, the configuration and all valids.
// A stalled m_tready holds only ticks that would produce a result.
module loop_playhead_controller_unit import lpc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,    // [15:0] speed_value, [32:16] int_value, [39:33] zero
  input  logic [1:0]  s_tuser,    // [1:0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,    // [15:0] frame_position, [16] looping, [23:17] zero
  input  logic        cfg_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic        enable;
  logic [15:0] clip_length;
  logic [7:0]  rate_scale;
  item_t       item;
  logic        item_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable      <= 1'b0;
      clip_length <= '0;
      rate_scale  <= '0;
    end else if (cfg_en) begin
      unique case (cfg_index)
        CFG_ENABLE:      enable      <= cfg_data[0];
        CFG_CLIP_LENGTH: clip_length <= cfg_data;
        CFG_RATE_SCALE:  rate_scale  <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Request intake and step computation
  lpc_step_pipe u_step_pipe (
    .clk            (clk),
    .rst            (rst),
    .rate_scale     (rate_scale),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .in_req         (req_t'(s_tuser)),
    .in_speed_value ($signed(s_tdata[15:0])),
    .in_int_value   ($signed(s_tdata[32:16])),
    .item           (item),
    .item_ready     (item_ready)
  );

  // Playhead state and result
  lpc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .enable      (enable),
    .clip_length (clip_length),
    .item        (item),
    .item_ready  (item_ready),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule

// ===== src/lpc_step_pipe.sv =====
// Intake pipeline: registers requests and computes the per-tick position step
// over three stages (product, reciprocal divide, remainder fix-up). Uses lpc_pkg.
module lpc_step_pipe import lpc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         rate_scale,
  input  logic               in_valid,
  output logic               in_ready,
  input  req_t               in_req,
  input  logic signed [15:0] in_speed_value,
  input  logic signed [16:0] in_int_value,
  output item_t              item,
  input  logic               item_ready
);

  localparam step_tab_t STEP_TAB = make_step_tab();

  // Speed in effect after every accepted request, tracked in order
  logic signed [15:0] shadow_speed;

  // Stage 1: product
  logic                      v1;
  req_t                      req1;
  logic signed [15:0]        sv1;
  logic signed [16:0]        iv1;
  logic signed [PROD_W-1:0]  prod1;

  // Stage 2: quotient
  logic                      v2;
  req_t                      req2;
  logic signed [15:0]        sv2;
  logic signed [16:0]        iv2;
  logic signed [PROD_W-1:0]  prod2;
  logic signed [QUOT_W-1:0]  quot2;

  // Stage 3 output register
  logic                      v3;
  req_t                      req3;
  logic signed [15:0]        sv3;
  logic signed [16:0]        iv3;
  logic signed [STEP_W-1:0]  step3;

  logic ready1, ready2, ready3;
  logic signed [15:0]         speed_eff;
  logic signed [PROD_W:0]     prod_full;
  logic [PROD_W:0]            mag_full;
  logic [PROD_W-1:0]          mag;
  logic [PROD_W+RECIP_W-1:0]  recip_prod;
  logic [QUOT_W-1:0]          quot_mag;
  logic signed [QUOT_W-1:0]   quot;
  logic signed [PROD_W+1:0]   quot_x25;
  logic signed [PROD_W+1:0]   rem_full;
  logic [REM_W-1:0]           rem;
  logic signed [STEP_W-1:0]   step;

  // Each stage takes a new entry when empty or when its contents move on
  assign ready3   = !v3 || item_ready;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1;

  // Stage 1 math: rate_scale times the speed in effect for this request
  assign speed_eff = (in_req == REQ_SPEED) ? in_speed_value : shadow_speed;
  assign prod_full = $signed({1'b0, rate_scale}) * speed_eff;

  // Stage 2 math: floor division by TICK_DIV through a reciprocal multiply
  assign mag_full   = prod1[PROD_W-1] ? (PROD_W+1)'(-prod1 + (PROD_W+1)'(TICK_DIV - 1))
                                      : (PROD_W+1)'(prod1);
  assign mag        = mag_full[PROD_W-1:0];
  assign recip_prod = (PROD_W+RECIP_W)'(mag) * (PROD_W+RECIP_W)'(RECIP_K);
  assign quot_mag   = recip_prod[RECIP_SH +: QUOT_W];
  assign quot       = prod1[PROD_W-1] ? -$signed(quot_mag) : $signed(quot_mag);

  // Stage 3 math: remainder, then scale to the position fraction
  assign quot_x25 = ((PROD_W+2)'(quot2) <<< 4) + ((PROD_W+2)'(quot2) <<< 3)
                    + (PROD_W+2)'(quot2);
  assign rem_full = (PROD_W+2)'(prod2) - quot_x25;
  assign rem      = rem_full[REM_W-1:0];
  assign step     = (STEP_W'(quot2) <<< STEP_SH)
                    + STEP_W'($signed({1'b0, STEP_TAB[rem]}));

  // Shadow speed follows accepted speed changes
  always_ff @(posedge clk) begin
    if (rst) begin
      shadow_speed <= '0;
    end else if (in_valid && ready1 && in_req == REQ_SPEED) begin
      shadow_speed <= in_speed_value;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ready1) v1 <= in_valid;
      if (ready2) v2 <= v1;
      if (ready3) v3 <= v2;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (ready1) begin
      req1  <= in_req;
      sv1   <= in_speed_value;
      iv1   <= in_int_value;
      prod1 <= prod_full[PROD_W-1:0];
    end
    if (ready2) begin
      req2  <= req1;
      sv2   <= sv1;
      iv2   <= iv1;
      prod2 <= prod1;
      quot2 <= quot;
    end
    if (ready3) begin
      req3  <= req2;
      sv3   <= sv2;
      iv3   <= iv2;
      step3 <= step;
    end
  end

  assign item.valid       = v3;
  assign item.req         = req3;
  assign item.speed_value = sv3;
  assign item.int_value   = iv3;
  assign item.step        = step3;

endmodule

// ===== src/lpc_core.sv =====
// Playhead state and its per-request update, with the result register.
// Takes requests from lpc_step_pipe; uses lpc_pkg.
module lpc_core import lpc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        enable,
  input  logic [15:0] clip_length,
  input  item_t       item,
  output logic        item_ready,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata     // [15:0] frame_position, [16] looping, [23:17] zero
);

  localparam logic signed [WIDE_W-1:0] POS_HI_W = WIDE_W'(POS_HI_L);
  localparam logic signed [WIDE_W-1:0] POS_LO_W = WIDE_W'(POS_LO_L);

  // Playhead state
  logic signed [POS_W-1:0]  position, position_next;
  logic signed [15:0]       speed, speed_next;
  logic [FRAME_BITS-1:0]    loop_start, loop_start_next;
  logic [FRAME_BITS-1:0]    loop_end, loop_end_next;
  logic                     loop_locked, loop_locked_next;
  logic [2:0]               loop_counter, loop_counter_next;
  trig_t                    trigger_state, trigger_state_next;

  // Result register
  logic                     out_valid;
  logic [15:0]              out_frame, out_frame_next;
  logic                     out_loop;

  logic                     gives_result;
  logic                     fire;
  logic [FRAME_BITS-1:0]    len;
  logic [FRAME_BITS:0]      cur_floor;
  logic [FRAME_BITS-1:0]    cur_frame;

  // Effective clip length
  always_comb begin
    if (LEN_CMP_W'(clip_length) > LEN_CMP_W'(FRAME_MAX)) begin
      len = FRAME_MAX;
    end else begin
      len = FRAME_BITS'(clip_length);
    end
  end

  // Current frame, saturated to the frame range, for storing as loop end
  assign cur_floor = position[POS_W-1:FRAC_BITS];
  assign cur_frame = cur_floor[FRAME_BITS] ? '0 : cur_floor[FRAME_BITS-1:0];

  // Process the head request when the result register can take its result
  assign gives_result = (item.req == REQ_TICK) && enable;
  assign item_ready   = !(gives_result && out_valid && !m_tready);
  assign fire         = item.valid && item_ready;

  // Next state for the request at the head
  always_comb begin
    logic signed [WIDE_W-1:0] p;
    logic signed [WIDE_W-1:0] li;
    logic signed [WIDE_W-1:0] lo;
    logic signed [WIDE_W-1:0] lw;
    logic [FRAME_BITS-1:0]    ls;
    logic [FRAME_BITS-1:0]    le;
    logic                     lk;
    logic [2:0]               cnt;
    logic                     back;
    logic                     trig_on;
    logic                     iv_pos;
    logic                     iv_zero;
    logic [LEN_CMP_W-1:0]     iv_w;
    logic [FRAME_BITS-1:0]    iv_c;
    logic [FRAME_BITS:0]      fl;
    logic [FRAME_BITS-1:0]    fs;

    position_next      = position;
    speed_next         = speed;
    loop_start_next    = loop_start;
    loop_end_next      = loop_end;
    loop_locked_next   = loop_locked;
    loop_counter_next  = loop_counter;
    trigger_state_next = trigger_state;
    out_frame_next     = out_frame;

    p       = '0;
    li      = '0;
    lo      = '0;
    lw      = '0;
    ls      = loop_start;
    le      = loop_end;
    lk      = loop_locked;
    cnt     = loop_counter;
    back    = speed[15];
    trig_on = (trigger_state != TRIG_ZERO);
    iv_pos  = !item.int_value[16] && (item.int_value != '0);
    iv_zero = (item.int_value == '0);
    iv_w    = LEN_CMP_W'(item.int_value[15:0]);
    iv_c    = '0;
    fl      = '0;
    fs      = '0;

    unique case (item.req)
      REQ_TICK: begin
        if (enable) begin
          // Repair loop points against the clip
          if (le > len) le = len;
          if (ls > len) ls = '0;
          if (ls == le) begin
            if (back) begin
              ls = len;
              le = '0;
            end else begin
              ls = '0;
              le = len;
            end
          end

          p  = WIDE_W'(position) + WIDE_W'(item.step);
          li = $signed(WIDE_W'({ls, {FRAC_BITS{1'b0}}}));
          lo = $signed(WIDE_W'({le, {FRAC_BITS{1'b0}}}));

          // Loop crossing and lock-in, by direction
          if (back) begin
            if (lk) begin
              if (ls < le) begin
                if (p > li && p < lo) begin
                  p = li + (p - lo);
                  if (cnt < CNT_MAX) cnt = cnt + 3'd1;
                end
              end else begin
                if (p < lo) begin
                  if (cnt < CNT_MAX) cnt = cnt + 3'd1;
                  p = li + (p - lo);
                end
                if (p > li) p = lo - (li - p);
              end
            end else if (trig_on) begin
              if (ls < le) begin
                if (p > li && p < lo) begin
                  lk  = 1'b1;
                  cnt = '0;
                end
              end else if (p < lo) begin
                lk  = 1'b1;
                cnt = '0;
              end
            end
          end else begin
            if (lk) begin
              if (ls > le) begin
                if (p < li && p > lo) begin
                  if (cnt < CNT_MAX) cnt = cnt + 3'd1;
                  p = li + (p - lo);
                end
              end else begin
                if (p > lo) begin
                  p = li + (p - lo);
                  if (cnt < CNT_MAX) cnt = cnt + 3'd1;
                end
                if (p < li) p = lo - (li - p);
              end
            end else if (trig_on) begin
              if (ls > le) begin
                if (p < li && p > lo) begin
                  lk  = 1'b1;
                  cnt = '0;
                end
              end else if (p > lo) begin
                lk  = 1'b1;
                cnt = '0;
              end
            end
          end

          // Too many loops under a held trigger: back to the whole clip
          if (trig_on && cnt > LOOP_LIMIT) begin
            lk  = 1'b0;
            cnt = '0;
            ls  = '0;
            le  = len;
          end

          // Wrap by one clip length, then clamp to the position range
          lw = $signed(WIDE_W'({len, {FRAC_BITS{1'b0}}}));
          if (p > lw) p = p - lw;
          if (p < 0) p = p + lw;
          if (p > POS_HI_W) p = POS_HI_W;
          if (p < POS_LO_W) p = POS_LO_W;

          // Output frame, saturated to 0..len
          fl = p[FRAC_BITS +: FRAME_BITS+1];
          if (fl[FRAME_BITS]) begin
            fs = '0;
          end else if (fl[FRAME_BITS-1:0] > len) begin
            fs = len;
          end else begin
            fs = fl[FRAME_BITS-1:0];
          end

          position_next     = POS_W'(p);
          loop_start_next   = ls;
          loop_end_next     = le;
          loop_locked_next  = lk;
          loop_counter_next = cnt;
          out_frame_next    = 16'(fs);
        end
      end

      REQ_SPEED: begin
        // Direction change swaps the loop points
        if ((!speed[15] && speed != '0) != (!item.speed_value[15] && item.speed_value != '0))
        begin
          loop_start_next = loop_end;
          loop_end_next   = loop_start;
        end
        speed_next = item.speed_value;
      end

      REQ_TRIGGER: begin
        if (iv_pos != (trigger_state == TRIG_POS)) begin
          if (iv_pos) begin
            trigger_state_next = TRIG_POS;
          end else if (iv_zero) begin
            trigger_state_next = TRIG_ZERO;
          end else begin
            trigger_state_next = TRIG_NEG;
          end
          if (!iv_zero) begin
            loop_locked_next = 1'b0;
            loop_end_next    = cur_frame;
            loop_start_next  = '0;
            position_next    = '0;
          end
        end
      end

      REQ_JUMP: begin
        if (item.int_value[16]) begin
          iv_c = '0;
        end else if (iv_w > LEN_CMP_W'(len)) begin
          iv_c = len;
        end else begin
          iv_c = FRAME_BITS'(iv_w);
        end
        loop_locked_next   = 1'b0;
        loop_end_next      = cur_frame;
        loop_start_next    = iv_c;
        position_next      = POS_W'({iv_c, {FRAC_BITS{1'b0}}});
        trigger_state_next = TRIG_POS;
      end

      default: begin
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      position      <= '0;
      speed         <= '0;
      loop_start    <= '0;
      loop_end      <= '0;
      loop_locked   <= 1'b0;
      loop_counter  <= '0;
      trigger_state <= TRIG_ZERO;
    end else if (fire) begin
      position      <= position_next;
      speed         <= speed_next;
      loop_start    <= loop_start_next;
      loop_end      <= loop_end_next;
      loop_locked   <= loop_locked_next;
      loop_counter  <= loop_counter_next;
      trigger_state <= trigger_state_next;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && gives_result) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (fire && gives_result) begin
      out_frame <= out_frame_next;
      out_loop  <= loop_locked_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_loop, out_frame};

  // A tick taken while enabled always leaves a result pending
  a_tick_result: assert property (@(posedge clk) disable iff (rst)
    (fire && gives_result) |=> out_valid)
    else $error("tick result not registered");

  // A jump leaves the position exactly on the new loop start
  a_jump_pos: assert property (@(posedge clk) disable iff (rst)
    (fire && item.req == REQ_JUMP) |=>
      (position[FRAC_BITS-1:0] == '0 && position[POS_W-1:FRAC_BITS] == {1'b0, loop_start}))
    else $error("jump position differs from loop start");

  // Reported frame never exceeds the clip length
  a_frame_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (LEN_CMP_W'(out_frame) <= LEN_CMP_W'(len)))
    else $error("frame position beyond clip length");

endmodule
